[rtl/assert_macros.svh]
// assertion macros for the reassembler rtl
// expects a clock named clk and a synchronous reset named rst in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ISOTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition implies consequence in the same cycle
`define ISOTP_ASSERT_SAME(label, cond, conseq, msg) \
  `ISOTP_ASSERT(label, (cond) |-> (conseq), msg)

// condition implies consequence in the following cycle
`define ISOTP_ASSERT_NEXT(label, cond, conseq, msg) \
  `ISOTP_ASSERT(label, (cond) |=> (conseq), msg)

`endif

[rtl/isotp_rx_pkg.sv]
// types, codes and sizing constants for the transport receive reassembler
// no dependencies; used by every rtl module of the block
package isotp_rx_pkg;

  // storage sizing
  localparam int PARTS_DEPTH   = 4096;
  localparam int PARTS_AW      = $clog2(PARTS_DEPTH);
  localparam int MSG_MAX       = 16;
  localparam int POS_W         = $clog2(MSG_MAX + 1);
  localparam int SINGLE_DEPTH  = 16;
  localparam int SINGLE_AW     = $clog2(SINGLE_DEPTH);
  localparam int OVERRUN_LIMIT = 32;
  localparam int LEN_W         = 13;
  localparam int EXP_W         = 12;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_ID     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SLICES = 1'b1;
  localparam logic [31:0] RECEIVE_ID_RESET     = 32'd2024;
  localparam logic [7:0]  TIMEOUT_SLICES_RESET = 8'd4;

  // pci frame kinds (high nibble of the pci byte)
  localparam logic [3:0] FK_SINGLE = 4'h0;
  localparam logic [3:0] FK_FIRST  = 4'h1;
  localparam logic [3:0] FK_CONSEC = 4'h2;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_READ     = 2'd3
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  data_byte;
    logic        last_of_message;
    logic [11:0] read_index;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] response_length;
    logic [7:0]       read_data;
  } out_item_t;

  // write requests into the payload stores
  typedef struct packed {
    logic                 parts_we;
    logic [PARTS_AW-1:0]  parts_addr;
    logic                 single_we;
    logic [SINGLE_AW-1:0] single_addr;
    logic [7:0]           wdata;
  } store_wr_t;

  // read request into the payload stores
  typedef struct packed {
    logic                 en;
    logic [PARTS_AW-1:0]  parts_addr;
    logic [SINGLE_AW-1:0] single_addr;
  } store_rd_t;

  // per-beat result info waiting for the store read data
  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] rlen;
    logic             sel_single;
    logic             parts_ok;
  } res_info_t;

endpackage

[rtl/isotp_rx_store.sv]
// payload stores: segmented payload memory and single frame buffer
// uses isotp_rx_pkg; one write and one registered read per cycle each
module isotp_rx_store (
  input  logic                   clk,
  input  isotp_rx_pkg::store_wr_t wr,
  input  isotp_rx_pkg::store_rd_t rd,
  output logic [7:0]             parts_q,
  output logic [7:0]             single_q
);

  logic [7:0] parts_mem  [isotp_rx_pkg::PARTS_DEPTH];
  logic [7:0] single_mem [isotp_rx_pkg::SINGLE_DEPTH];

  // segmented payload memory
  always_ff @(posedge clk) begin
    if (wr.parts_we) begin
      parts_mem[wr.parts_addr] <= wr.wdata;
    end
    if (rd.en) begin
      parts_q <= parts_mem[rd.parts_addr];
    end
  end

  // single frame buffer
  always_ff @(posedge clk) begin
    if (wr.single_we) begin
      single_mem[wr.single_addr] <= wr.wdata;
    end
    if (rd.en) begin
      single_q <= single_mem[rd.single_addr];
    end
  end

endmodule

[rtl/isotp_rx_ctrl.sv]
// session and frame control: parses message bytes, tracks lengths and timeout
// uses isotp_rx_pkg; drives store writes/reads and the per-beat result info
module isotp_rx_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [isotp_rx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isotp_rx_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                 fire,
  input  isotp_rx_pkg::in_item_t               item,
  output isotp_rx_pkg::store_wr_t              wr,
  output isotp_rx_pkg::store_rd_t              rd,
  output isotp_rx_pkg::res_info_t              res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACTIVE = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  localparam int LW = isotp_rx_pkg::LEN_W;
  localparam int PW = isotp_rx_pkg::POS_W;

  phase_t                          phase, phase_next;
  logic [PW-1:0]                   pos, pos_next;
  logic [31:0]                     msg_id, msg_id_next;
  logic [3:0]                      frame_kind, frame_kind_next;
  logic [3:0]                      single_len, single_len_next;
  logic [isotp_rx_pkg::EXP_W-1:0]  expected_len, expected_len_next;
  logic [LW-1:0]                   collected_len, collected_len_next;
  logic [7:0]                      slices_left, slices_left_next;
  logic                            from_single, from_single_next;
  logic                            msg_live, msg_live_next;
  logic [31:0]                     receive_id;
  logic [7:0]                      timeout_slices;

  // derived message arithmetic
  logic          pos_room;
  logic [PW-1:0] off5, off6, len_msg, chunk;
  logic [LW:0]   cons_addr, coll_sum;
  logic [LW-1:0] coll_v;
  logic [7:0]    slices_dec;

  assign pos_room   = pos < PW'(isotp_rx_pkg::MSG_MAX);
  assign off5       = pos - PW'(5);
  assign off6       = pos - PW'(6);
  assign len_msg    = pos_room ? pos + PW'(1) : pos;
  assign chunk      = len_msg - PW'(5);
  assign cons_addr  = (LW + 1)'(collected_len) + (LW + 1)'(off5);
  assign coll_sum   = (LW + 1)'(collected_len) + (LW + 1)'(chunk);
  assign coll_v     = (coll_sum <= (LW + 1)'(isotp_rx_pkg::PARTS_DEPTH))
                      ? coll_sum[LW-1:0] : collected_len;
  assign slices_dec = (slices_left != 8'd0) ? slices_left - 8'd1 : slices_left;

  // store read request straight from the accepted beat
  assign rd.en          = fire && (item.mode == isotp_rx_pkg::MODE_READ);
  assign rd.parts_addr  = isotp_rx_pkg::PARTS_AW'(item.read_index);
  assign rd.single_addr = item.read_index[isotp_rx_pkg::SINGLE_AW-1:0];

  // next state, store writes and result for the accepted beat
  always_comb begin
    phase_next         = phase;
    pos_next           = pos;
    msg_id_next        = msg_id;
    frame_kind_next    = frame_kind;
    single_len_next    = single_len;
    expected_len_next  = expected_len;
    collected_len_next = collected_len;
    slices_left_next   = slices_left;
    from_single_next   = from_single;
    msg_live_next      = msg_live;
    wr                 = '0;
    wr.wdata           = item.data_byte;
    res                = '0;
    res.status         = isotp_rx_pkg::ST_NONE;
    res.sel_single     = from_single;
    res.parts_ok       = LW'(item.read_index) < LW'(isotp_rx_pkg::PARTS_DEPTH);

    unique case (item.mode)
      isotp_rx_pkg::MODE_START: begin
        phase_next         = PH_ACTIVE;
        expected_len_next  = '0;
        collected_len_next = '0;
        from_single_next   = 1'b0;
        msg_live_next      = 1'b0;
        slices_left_next   = timeout_slices;
        if (timeout_slices == 8'd0) begin
          phase_next = PH_IDLE;
          res.status = isotp_rx_pkg::ST_TIMEOUT;
        end
      end

      isotp_rx_pkg::MODE_BYTE: begin
        // per-byte parsing while the message still has room
        if (pos_room) begin
          if (pos < PW'(4)) begin
            msg_id_next = {msg_id[23:0], item.data_byte};
          end else if (pos == PW'(4)) begin
            frame_kind_next = item.data_byte[7:4];
            single_len_next = item.data_byte[3:0];
            msg_live_next   = (phase == PH_ACTIVE) && (msg_id == receive_id);
            if (msg_live_next && item.data_byte[7:4] == isotp_rx_pkg::FK_FIRST) begin
              expected_len_next  = {item.data_byte[3:0], 8'h00};
              collected_len_next = '0;
            end
          end else if (msg_live) begin
            unique case (frame_kind)
              isotp_rx_pkg::FK_SINGLE: begin
                wr.single_we   = 8'(off5) < 8'(isotp_rx_pkg::SINGLE_DEPTH);
                wr.single_addr = isotp_rx_pkg::SINGLE_AW'(off5);
              end
              isotp_rx_pkg::FK_FIRST: begin
                if (pos == PW'(5)) begin
                  expected_len_next = {expected_len[11:8], item.data_byte};
                end else if (LW'(off6) < LW'(isotp_rx_pkg::PARTS_DEPTH)) begin
                  wr.parts_we        = 1'b1;
                  wr.parts_addr      = isotp_rx_pkg::PARTS_AW'(off6);
                  collected_len_next = collected_len + LW'(1);
                end
              end
              isotp_rx_pkg::FK_CONSEC: begin
                wr.parts_we   = cons_addr < (LW + 1)'(isotp_rx_pkg::PARTS_DEPTH);
                wr.parts_addr = cons_addr[isotp_rx_pkg::PARTS_AW-1:0];
              end
              default: begin
              end
            endcase
          end
          pos_next = len_msg;
        end

        // end of message: check for completion
        if (item.last_of_message) begin
          if (msg_live_next && 8'(len_msg) >= 8'd5) begin
            if (frame_kind_next == isotp_rx_pkg::FK_SINGLE) begin
              if (8'(single_len_next) + 8'd5 <= 8'(len_msg)) begin
                res.status         = isotp_rx_pkg::ST_COMPLETE;
                res.rlen           = LW'(single_len_next);
                phase_next         = PH_DONE;
                collected_len_next = LW'(single_len_next);
                from_single_next   = 1'b1;
              end
            end else if (frame_kind_next == isotp_rx_pkg::FK_CONSEC) begin
              collected_len_next = coll_v;
              if (expected_len != '0 && coll_v >= LW'(expected_len)) begin
                res.status         = isotp_rx_pkg::ST_COMPLETE;
                res.rlen           = LW'(expected_len);
                phase_next         = PH_DONE;
                collected_len_next = LW'(expected_len);
                from_single_next   = 1'b0;
              end else if (coll_v > LW'(isotp_rx_pkg::OVERRUN_LIMIT)) begin
                res.status       = isotp_rx_pkg::ST_COMPLETE;
                res.rlen         = coll_v;
                phase_next       = PH_DONE;
                from_single_next = 1'b0;
              end
            end
          end
          pos_next      = '0;
          msg_live_next = 1'b0;
        end
      end

      isotp_rx_pkg::MODE_TICK: begin
        if (phase == PH_ACTIVE) begin
          slices_left_next = slices_dec;
          if (slices_dec == 8'd0) begin
            phase_next    = PH_IDLE;
            msg_live_next = 1'b0;
            res.status    = isotp_rx_pkg::ST_TIMEOUT;
          end
        end
      end

      isotp_rx_pkg::MODE_READ: begin
        if (phase == PH_DONE && LW'(item.read_index) < collected_len) begin
          res.status = isotp_rx_pkg::ST_READ;
          res.rlen   = collected_len;
        end
      end

      default: begin
      end
    endcase

    wr.parts_we  = wr.parts_we && fire;
    wr.single_we = wr.single_we && fire;
  end

  // session state, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pos           <= '0;
      msg_id        <= '0;
      frame_kind    <= '0;
      single_len    <= '0;
      expected_len  <= '0;
      collected_len <= '0;
      slices_left   <= '0;
      from_single   <= 1'b0;
      msg_live      <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      pos           <= pos_next;
      msg_id        <= msg_id_next;
      frame_kind    <= frame_kind_next;
      single_len    <= single_len_next;
      expected_len  <= expected_len_next;
      collected_len <= collected_len_next;
      slices_left   <= slices_left_next;
      from_single   <= from_single_next;
      msg_live      <= msg_live_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      receive_id     <= isotp_rx_pkg::RECEIVE_ID_RESET;
      timeout_slices <= isotp_rx_pkg::TIMEOUT_SLICES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        isotp_rx_pkg::CFG_RECEIVE_ID:     receive_id     <= cfg_data;
        isotp_rx_pkg::CFG_TIMEOUT_SLICES: timeout_slices <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/isotp_rx_out.sv]
// result stage: joins the result info with store read data, output register
// uses isotp_rx_pkg; holds one beat in flight and one finished result
module isotp_rx_out (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  isotp_rx_pkg::res_info_t res,
  input  logic [7:0]              parts_q,
  input  logic [7:0]              single_q,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output isotp_rx_pkg::out_item_t out_data
);

  logic                    p_valid;
  isotp_rx_pkg::res_info_t p_info;
  logic                    adv;
  logic [7:0]              rdata;

  // pipeline moves when the output register is empty or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = p_valid && !adv;

  // pick the byte for a read beat
  always_comb begin
    rdata = 8'd0;
    if (p_info.status == isotp_rx_pkg::ST_READ) begin
      if (p_info.sel_single) begin
        rdata = single_q;
      end else if (p_info.parts_ok) begin
        rdata = parts_q;
      end
    end
  end

  // beat waiting for store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (fire) begin
      p_valid <= 1'b1;
    end else if (adv) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      p_info <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_valid) begin
      out_data.status          <= p_info.status;
      out_data.response_length <= p_info.rlen;
      out_data.read_data       <= rdata;
    end
  end

endmodule

[rtl/isotp_receive_reassembler_core.sv]
// top level of the transport receive reassembler
// uses isotp_rx_pkg, isotp_rx_ctrl, isotp_rx_store, isotp_rx_out and assert_macros.svh

// Takes one beat per clock while in_stall is low and returns one result beat
// for every beat taken. On acceptance the session state is updated, the
// message byte is parsed and the 4096 x 8 payload memory (one write and one
// registered read port) or the 16 x 8 single frame buffer is written or read;
// the result info is registered beside the store read data, and the result is
// then formed in the output register. in_stall rises only when both the
// in-flight beat and the output register are held by out_stall. Configuration
// writes are registered and should be made while no beat is in flight. A read
// is answered only below the completed length, so only payload bytes written
// in the current session come back.
module isotp_receive_reassembler_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [isotp_rx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isotp_rx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  isotp_rx_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output isotp_rx_pkg::out_item_t             out_data
);

`include "assert_macros.svh"

  logic                    fire;
  isotp_rx_pkg::store_wr_t wr;
  isotp_rx_pkg::store_rd_t rd;
  isotp_rx_pkg::res_info_t res;
  logic [7:0]              parts_q;
  logic [7:0]              single_q;

  assign fire = in_valid && !in_stall;

  // session control
  isotp_rx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (in_data),
    .wr        (wr),
    .rd        (rd),
    .res       (res)
  );

  // payload stores
  isotp_rx_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd       (rd),
    .parts_q  (parts_q),
    .single_q (single_q)
  );

  // result stage
  isotp_rx_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .parts_q   (parts_q),
    .single_q  (single_q),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `ISOTP_ASSERT_SAME(a_read_data_gated,
    out_valid && out_data.status != isotp_rx_pkg::ST_READ,
    out_data.read_data == 8'd0, "read data on a non-read result")
  `ISOTP_ASSERT_SAME(a_timeout_no_len,
    out_valid && out_data.status == isotp_rx_pkg::ST_TIMEOUT,
    out_data.response_length == '0, "length on a timeout result")
  `ISOTP_ASSERT_SAME(a_stall_when_full, in_stall, out_valid && out_stall,
    "input stalled with room in the pipeline")
  `ISOTP_ASSERT_SAME(a_store_write_live, wr.parts_we || wr.single_we, !(rd.en),
    "store read and write from one beat")

endmodule
